/* hw/rtl/eventual_safe_nodes_assert.svh */
// Assertion macros shared by the eventual safe nodes RTL.
`ifndef EVENTUAL_SAFE_NODES_ASSERT_SVH
`define EVENTUAL_SAFE_NODES_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ESN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ESN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/esn_pkg.sv */
// Shared types and constants for the eventual safe nodes block.
`timescale 1ns / 1ps
package esn_pkg;

  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [NODE_W-1:0] rd_node;
    logic              wr_en;
    logic [NODE_W-1:0] wr_node;
    logic              clear;
  } deg_ctl_t;

endpackage

/* hw/rtl/esn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module esn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/esn_deg_unit.sv */
// Out-degree store: RAM, per-entry valid bits and write-to-read forwarding.
`timescale 1ns / 1ps
`include "eventual_safe_nodes_assert.svh"
module esn_deg_unit #(
  parameter int MAX_NODES = 64,
  parameter int DEG_W     = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  esn_pkg::deg_ctl_t ctl,
  input  logic [DEG_W-1:0]  wr_data,
  output logic [DEG_W-1:0]  rd_data
);
  import esn_pkg::*;

  localparam int NA_W = $clog2(MAX_NODES);

  logic [MAX_NODES-1:0] vld_r;
  logic                 vld_rd_r;
  logic [NA_W-1:0]      rd_addr_r;
  logic [NA_W-1:0]      wr_addr_r;
  logic                 wr_en_r;
  logic [DEG_W-1:0]     wr_data_r;
  logic [DEG_W-1:0]     ram_rdata;

  esn_ram #(
    .WIDTH (DEG_W),
    .DEPTH (MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (ctl.wr_node[NA_W-1:0]),
    .wdata (wr_data),
    .raddr (ctl.rd_node[NA_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      wr_en_r <= 1'b0;
    end else begin
      if (ctl.clear) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[ctl.wr_node[NA_W-1:0]] <= 1'b1;
      end
      wr_en_r <= ctl.wr_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= ctl.rd_node[NA_W-1:0];
    vld_rd_r  <= vld_r[ctl.rd_node[NA_W-1:0]];
    wr_addr_r <= ctl.wr_node[NA_W-1:0];
    wr_data_r <= wr_data;
  end

  // previous-cycle write to the same entry wins over the RAM's old data
  assign rd_data = (wr_en_r && (wr_addr_r == rd_addr_r)) ? wr_data_r :
                   (vld_rd_r ? ram_rdata : '0);

  `ESN_ASSERT_IMP(a_clear_no_write, ctl.clear, !ctl.wr_en, "degree clear with write pending")
  `ESN_ASSERT_NXT(a_write_valid, ctl.wr_en && !ctl.clear, vld_r[$past(ctl.wr_node[NA_W-1:0])], "written degree entry not valid")
  `ESN_ASSERT_NXT(a_clear_done, ctl.clear, vld_r == '0, "degree valid bits survive clear")

endmodule

/* hw/rtl/eventual_safe_nodes.sv */
// Top level: eventually safe nodes of a directed graph by reverse Kahn sort.
//
// Input: an item is taken on a clock edge with start high and busy low. Each
// item may carry one edge (in_from_node -> in_to_node); items load one per
// cycle. An edge with a node at or above node_count is ignored; an edge past
// MAX_EDGES stored is dropped and reported by out_edge_overflow.
// The item with in_last_edge high starts the computation and raises busy.
// Computation: a scan queues terminal nodes; each popped node then reads every
// stored edge, one edge read per cycle from the edge RAM, and the computation
// ends when the queue is found empty.
// Results: n results, one per cycle, node 0 first, each marked by out_valid
// for one cycle; out_last_node flags node n-1. busy drops as the last result
// goes out, and the next graph may load from that cycle on.
// The receiver cannot stall; results are never held back.
// Config: cfg_node_count is written on cfg_valid & cfg_ready, only while busy
// is low. 0 acts as 1 and values above MAX_NODES act as MAX_NODES.
// Reset: node_count becomes 64 and the graph store is empty.
`timescale 1ns / 1ps
`include "eventual_safe_nodes_assert.svh"
module eventual_safe_nodes #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [esn_pkg::NODE_W-1:0]  in_from_node,
  input  logic [esn_pkg::NODE_W-1:0]  in_to_node,
  input  logic                        in_edge_present,
  input  logic                        in_last_edge,
  output logic                        out_valid,
  output logic [esn_pkg::NODE_W-1:0]  out_node_index,
  output logic                        out_is_safe,
  output logic                        out_edge_overflow,
  output logic                        out_last_node,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [esn_pkg::CNT_W-1:0]   cfg_node_count
);
  import esn_pkg::*;

  localparam int NA_W  = $clog2(MAX_NODES);
  localparam int EC_W  = $clog2(MAX_EDGES + 1);
  localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DEG_W = EC_W;
  localparam logic [CNT_W-1:0] MAXN = CNT_W'(MAX_NODES);
  localparam logic [EC_W-1:0]  MAXE = EC_W'(MAX_EDGES);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_POPW = 3'd3;
  localparam logic [2:0] S_EDGE = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     node_count_r;
  logic [CNT_W-1:0]     n_eff;
  logic [EC_W-1:0]      stored_r, stored_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     scnt_r, scnt_nxt;
  logic [CNT_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     ocnt_r, ocnt_nxt;
  logic [EC_W-1:0]      ecnt_r, ecnt_nxt;
  logic                 l1_vld_r, l1_vld_nxt;
  logic [NODE_W-1:0]    l1_node_r;
  logic                 s_vld_r, s_vld_nxt;
  logic [NODE_W-1:0]    s_node_r;
  logic                 e1_vld_r, e1_vld_nxt;
  logic                 e2_vld_r, e2_vld_nxt;
  logic [NODE_W-1:0]    e2_src_r;
  logic [NODE_W-1:0]    f_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]    out_node_r;
  logic                 out_ovf_r, out_last_r;
  logic                 clear_graph;

  logic                 acc, edge_ok, edge_store;
  logic [NODE_W-1:0]    e_src, e_tgt;
  logic [2*NODE_W-1:0]  edge_rdata;
  logic [NODE_W-1:0]    q_rdata;
  logic                 push_en;
  logic [NODE_W-1:0]    push_node;
  deg_ctl_t             deg_ctl;
  logic [DEG_W-1:0]     deg_wdata, deg_rd;

  assign busy      = (state_r != S_LOAD);
  assign cfg_ready = !busy;

  always_comb begin
    if (node_count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_count_r > MAXN) begin
      n_eff = MAXN;
    end else begin
      n_eff = node_count_r;
    end
  end

  assign acc        = start && !busy;
  assign edge_ok    = acc && in_edge_present && ({1'b0, in_from_node} < n_eff) &&
                      ({1'b0, in_to_node} < n_eff);
  assign edge_store = edge_ok && (stored_r < MAXE);

  assign e_src = edge_rdata[2*NODE_W-1:NODE_W];
  assign e_tgt = edge_rdata[NODE_W-1:0];

  esn_ram #(
    .WIDTH (2 * NODE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_store),
    .waddr (stored_r[EA_W-1:0]),
    .wdata ({in_from_node, in_to_node}),
    .raddr (ecnt_r[EA_W-1:0]),
    .rdata (edge_rdata)
  );

  esn_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_queue_ram (
    .clk   (clk),
    .we    (push_en),
    .waddr (tail_r[NA_W-1:0]),
    .wdata (push_node),
    .raddr (head_r[NA_W-1:0]),
    .rdata (q_rdata)
  );

  esn_deg_unit #(
    .MAX_NODES (MAX_NODES),
    .DEG_W     (DEG_W)
  ) u_deg (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (deg_ctl),
    .wr_data (deg_wdata),
    .rd_data (deg_rd)
  );

  // degree read select, read-modify-write and queue push
  always_comb begin
    deg_ctl         = '0;
    deg_wdata       = '0;
    push_en         = 1'b0;
    push_node       = '0;
    deg_ctl.clear   = clear_graph;
    case (state_r)
      S_LOAD:  deg_ctl.rd_node = in_from_node;
      S_SCAN:  deg_ctl.rd_node = scnt_r[NODE_W-1:0];
      S_EDGE:  deg_ctl.rd_node = e_src;
      S_EMIT:  deg_ctl.rd_node = ocnt_r[NODE_W-1:0];
      default: deg_ctl.rd_node = '0;
    endcase
    if (l1_vld_r) begin
      deg_ctl.wr_en   = 1'b1;
      deg_ctl.wr_node = l1_node_r;
      deg_wdata       = deg_rd + DEG_W'(1);
    end else if (e2_vld_r && (deg_rd != '0)) begin
      deg_ctl.wr_en   = 1'b1;
      deg_ctl.wr_node = e2_src_r;
      deg_wdata       = deg_rd - DEG_W'(1);
    end
    if (s_vld_r && (deg_rd == '0)) begin
      push_en   = 1'b1;
      push_node = s_node_r;
    end else if (e2_vld_r && (deg_rd == DEG_W'(1))) begin
      push_en   = 1'b1;
      push_node = e2_src_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    stored_nxt    = stored_r;
    ovf_nxt       = ovf_r;
    scnt_nxt      = scnt_r;
    head_nxt      = head_r;
    tail_nxt      = push_en ? tail_r + CNT_W'(1) : tail_r;
    ocnt_nxt      = ocnt_r;
    ecnt_nxt      = ecnt_r;
    l1_vld_nxt    = 1'b0;
    s_vld_nxt     = 1'b0;
    e1_vld_nxt    = 1'b0;
    e2_vld_nxt    = e1_vld_r && (e_tgt == f_r) && ({1'b0, e_src} < n_eff);
    out_valid_nxt = 1'b0;
    clear_graph   = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (edge_store) begin
          stored_nxt = stored_r + EC_W'(1);
          l1_vld_nxt = 1'b1;
        end
        if (edge_ok && !edge_store) begin
          ovf_nxt = 1'b1;
        end
        if (acc && in_last_edge) begin
          state_nxt = S_SCAN;
          scnt_nxt  = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
        end
      end
      S_SCAN: begin
        if (scnt_r < n_eff) begin
          s_vld_nxt = 1'b1;
          scnt_nxt  = scnt_r + CNT_W'(1);
        end else if (!s_vld_r) begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (head_r == tail_r) begin
          state_nxt = S_EMIT;
          ocnt_nxt  = '0;
        end else begin
          head_nxt  = head_r + CNT_W'(1);
          state_nxt = S_POPW;
        end
      end
      S_POPW: begin
        ecnt_nxt  = '0;
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        if (ecnt_r < stored_r) begin
          e1_vld_nxt = 1'b1;
          ecnt_nxt   = ecnt_r + EC_W'(1);
        end else if (!e1_vld_r && !e2_vld_r) begin
          state_nxt = S_POP;
        end
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        ocnt_nxt      = ocnt_r + CNT_W'(1);
        if (ocnt_r + CNT_W'(1) == n_eff) begin
          state_nxt   = S_LOAD;
          clear_graph = 1'b1;
          stored_nxt  = '0;
          ovf_nxt     = 1'b0;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      node_count_r <= NODE_COUNT_RST;
      stored_r     <= '0;
      ovf_r        <= 1'b0;
      scnt_r       <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      ocnt_r       <= '0;
      ecnt_r       <= '0;
      l1_vld_r     <= 1'b0;
      s_vld_r      <= 1'b0;
      e1_vld_r     <= 1'b0;
      e2_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      stored_r <= stored_nxt;
      ovf_r    <= ovf_nxt;
      scnt_r   <= scnt_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      ocnt_r   <= ocnt_nxt;
      ecnt_r   <= ecnt_nxt;
      l1_vld_r <= l1_vld_nxt;
      s_vld_r  <= s_vld_nxt;
      e1_vld_r <= e1_vld_nxt;
      e2_vld_r <= e2_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    l1_node_r <= in_from_node;
    s_node_r  <= scnt_r[NODE_W-1:0];
    e2_src_r  <= e_src;
    if (state_r == S_POPW) begin
      f_r <= q_rdata;
    end
    out_node_r <= ocnt_r[NODE_W-1:0];
    out_ovf_r  <= ovf_r;
    out_last_r <= (ocnt_r + CNT_W'(1) == n_eff);
  end

  // a node is safe exactly when its remaining out-degree has reached zero
  assign out_valid         = out_valid_r;
  assign out_node_index    = out_node_r;
  assign out_is_safe       = (deg_rd == '0);
  assign out_edge_overflow = out_ovf_r;
  assign out_last_node     = out_last_r;

  `ESN_ASSERT_IMP(a_queue_order, busy, (head_r <= tail_r) && (tail_r <= n_eff), "work queue pointers out of order")
  `ESN_ASSERT_NXT(a_start_scan, start && !busy && in_last_edge, state_r == S_SCAN, "last item did not start the scan")
  `ESN_ASSERT_NXT(a_last_ends, out_valid && out_last_node, !out_valid, "results continue after last node")
  `ESN_ASSERT_IMP(a_emit_quiet, state_r == S_EMIT, !l1_vld_r && !s_vld_r && !e1_vld_r && !e2_vld_r, "pipeline busy during result transfer")

endmodule

/* tb/tb_eventual_safe_nodes.sv */
// Self-checking testbench for eventual_safe_nodes: directed table, edge-store overflow, then random graphs.
`timescale 1ns / 1ps
module tb_eventual_safe_nodes;
  import esn_pkg::*;

  localparam int NODES = 64;
  localparam int EDGES = 256;
  localparam int RAND_ITEMS = 80;
  localparam int SETTLE = 4;
  localparam int QUIET_LIMIT = 60000;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CNT_W-1:0] count;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic             present;
    logic             last;
    bit               typed;
    int unsigned      t_n;
    logic [63:0]      t_safe;
  } dir_row_t;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic              safe;
    logic              ovf;
    logic              last;
  } node_verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [NODE_W-1:0] in_from_node = '0;
  logic [NODE_W-1:0] in_to_node = '0;
  logic in_edge_present = 1'b0;
  logic in_last_edge = 1'b0;
  logic out_valid;
  logic [NODE_W-1:0] out_node_index;
  logic out_is_safe;
  logic out_edge_overflow;
  logic out_last_node;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_node_count = '0;

  always #6 clk = ~clk;

  eventual_safe_nodes #(
    .MAX_NODES(NODES),
    .MAX_EDGES(EDGES)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_from_node(in_from_node),
    .in_to_node(in_to_node),
    .in_edge_present(in_edge_present),
    .in_last_edge(in_last_edge),
    .out_valid(out_valid),
    .out_node_index(out_node_index),
    .out_is_safe(out_is_safe),
    .out_edge_overflow(out_edge_overflow),
    .out_last_node(out_last_node),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_node_count(cfg_node_count)
  );

  // graph model state
  logic [CNT_W-1:0]  node_count_q = NODE_COUNT_RST;
  logic [NODE_W-1:0] src_mem [EDGES];
  logic [NODE_W-1:0] dst_mem [EDGES];
  int unsigned       out_deg [NODES];
  bit [NODES-1:0]    safe_set = '0;
  int unsigned       edge_cnt = 0;
  bit                ovf_flag = 1'b0;

  node_verdict_t node_verdicts[$];
  dir_row_t      dir_rows[$];

  int errors = 0;
  int items_sent = 0;
  int rand_items = 0;
  int graphs_done = 0;
  int ovf_graphs = 0;
  int cfg_writes = 0;
  int results_checked = 0;
  int quiet = 0;

  task automatic report(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic int unsigned live_nodes();
    if (node_count_q == 0) return 1;
    if (node_count_q > NODES) return NODES;
    return node_count_q;
  endfunction

  task automatic load_edge(input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] d,
                           input logic p);
    int unsigned n;
    n = live_nodes();
    if (p && s < n && d < n) begin
      if (edge_cnt < EDGES) begin
        src_mem[edge_cnt] = s;
        dst_mem[edge_cnt] = d;
        edge_cnt++;
        out_deg[s]++;
      end else begin
        ovf_flag = 1'b1;
      end
    end
  endtask

  // reverse Kahn pass over the stored edges, then one verdict per node
  task automatic solve_graph(input bit typed, input int unsigned t_n, input logic [63:0] t_safe);
    int unsigned n;
    int unsigned f;
    int unsigned s;
    int unsigned cnt;
    logic [NODE_W-1:0] ready_q[$];
    node_verdict_t r;
    n = live_nodes();
    for (int v = 0; v < n; v++)
      if (out_deg[v] == 0) ready_q = {ready_q, NODE_W'(v)};
    while (ready_q.size() > 0) begin
      f = ready_q.pop_front();
      safe_set[f] = 1'b1;
      for (int e = 0; e < edge_cnt; e++) begin
        s = src_mem[e];
        if (dst_mem[e] != f || s >= n) continue;
        if (out_deg[s] == 0) continue;
        out_deg[s]--;
        if (out_deg[s] == 0) ready_q = {ready_q, NODE_W'(s)};
      end
    end
    cnt = typed ? t_n : n;
    for (int v = 0; v < cnt; v++) begin
      r.node = NODE_W'(v);
      r.safe = typed ? t_safe[v] : safe_set[v];
      r.ovf  = typed ? 1'b0 : ovf_flag;
      r.last = (v + 1 == cnt);
      node_verdicts = {node_verdicts, r};
    end
    if (ovf_flag) ovf_graphs++;
    graphs_done++;
    foreach (out_deg[i]) out_deg[i] = 0;
    safe_set = '0;
    edge_cnt = 0;
    ovf_flag = 1'b0;
  endtask

  task automatic send_item(input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] d,
                           input logic p, input logic l, input int gap,
                           input bit typed, input int unsigned t_n, input logic [63:0] t_safe);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_from_node <= s;
    in_to_node <= d;
    in_edge_present <= p;
    in_last_edge <= l;
    do @(posedge clk); while (busy);
    items_sent++;
    load_edge(s, d, p);
    if (l) solve_graph(typed, t_n, t_safe);
  endtask

  // register writes only once the block has drained
  task automatic set_node_count(input logic [CNT_W-1:0] v, input int gap);
    @(negedge clk);
    start <= 1'b0;
    while (node_verdicts.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE + gap) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_node_count <= v;
    do @(posedge clk); while (!cfg_ready);
    node_count_q = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(input row_kind_t k, input logic [CNT_W-1:0] c,
                                  input logic [NODE_W-1:0] s, input logic [NODE_W-1:0] d,
                                  input logic p, input logic l, input bit typed,
                                  input int unsigned t_n, input logic [63:0] t_safe);
    dir_row_t r;
    r.kind = k;
    r.count = c;
    r.src = s;
    r.dst = d;
    r.present = p;
    r.last = l;
    r.typed = typed;
    r.t_n = t_n;
    r.t_safe = t_safe;
    dir_rows = {dir_rows, r};
  endfunction

  always @(posedge clk) begin
    node_verdict_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (node_verdicts.size() == 0) begin
          report($sformatf("node %0d result with nothing expected", out_node_index));
        end else begin
          want = node_verdicts.pop_front();
          results_checked++;
          if (out_node_index !== want.node)
            report($sformatf("node_index %0d, want %0d", out_node_index, want.node));
          if (out_is_safe !== want.safe)
            report($sformatf("node %0d is_safe %b, want %b", want.node, out_is_safe, want.safe));
          if (out_edge_overflow !== want.ovf)
            report($sformatf("node %0d edge_overflow %b, want %b", want.node,
                             out_edge_overflow, want.ovf));
          if (out_last_node !== want.last)
            report($sformatf("node %0d last_node %b, want %b", want.node,
                             out_last_node, want.last));
        end
      end
    end
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
      quiet = 0;
    else
      quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("tb_eventual_safe_nodes NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int extra;
    int r;
    int gap;
    bit bursty;
    bit tail;
    logic [NODE_W-1:0] s;
    logic [NODE_W-1:0] d;
    logic p;

    foreach (out_deg[i]) out_deg[i] = 0;

    // after reset: 64 nodes, no edges
    add_row(ROW_ITEM, 0, 6'd0, 6'd0, 1'b0, 1'b1, 1, 64, '1);
    // single node with a self loop
    add_row(ROW_CFG, 7'd1, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd0, 6'd0, 1'b1, 1'b1, 1, 1, 64'h0);
    // count 0 acts as 1; out-of-range edge ignored
    add_row(ROW_CFG, 7'd0, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd1, 6'd0, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd63, 6'd63, 1'b0, 1'b1, 1, 1, 64'h1);
    // count above max saturates; edge carried on the last item
    add_row(ROW_CFG, 7'd127, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd0, 6'd63, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd63, 6'd63, 1'b1, 1'b1, 1, 64, 64'h7FFF_FFFF_FFFF_FFFE);
    // duplicate edges, empty last item with junk fields
    add_row(ROW_CFG, 7'd64, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd63, 6'd0, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd0, 6'd1, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd0, 6'd1, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd42, 6'd21, 1'b0, 1'b1, 1, 64, '1);
    // mixed cycle and chain, ignored edges and an empty item
    add_row(ROW_CFG, 7'd8, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd9, 6'd2, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd2, 6'd8, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd7, 6'd7, 1'b0, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd1, 6'd2, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd2, 6'd1, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd3, 6'd1, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd4, 6'd5, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd6, 6'd4, 1'b1, 1'b1, 0, 0, 0);
    // count shrinks mid-graph below a stored target
    add_row(ROW_CFG, 7'd16, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd10, 6'd12, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd3, 6'd10, 1'b1, 1'b0, 0, 0, 0);
    add_row(ROW_CFG, 7'd11, 0, 0, 0, 0, 0, 0, 0);
    add_row(ROW_ITEM, 0, 6'd5, 6'd5, 1'b0, 1'b1, 0, 0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_node_count(dir_rows[i].count, 0);
      else
        send_item(dir_rows[i].src, dir_rows[i].dst, dir_rows[i].present, dir_rows[i].last,
                  0, dir_rows[i].typed, dir_rows[i].t_n, dir_rows[i].t_safe);
    end

    // fill the edge store past capacity
    set_node_count(CNT_W'($urandom_range(2, 6)), 0);
    for (int k = 0; k < EDGES + 4; k++) begin
      n = live_nodes();
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
      send_item(NODE_W'($urandom_range(0, n - 1)), NODE_W'($urandom_range(0, n - 1)), 1'b1,
                k == EDGES + 3, gap, 0, 0, 0);
    end

    while (rand_items < RAND_ITEMS) begin
      tail = rand_items >= RAND_ITEMS - 60;
      if ($urandom_range(0, 2) == 0) begin
        gap = (!tail && $urandom_range(0, 1) == 0) ? $urandom_range(1, 10) : 0;
        if ($urandom_range(0, 3) == 0)
          set_node_count(CNT_W'($urandom_range(0, 127)), gap);
        else
          set_node_count(CNT_W'($urandom_range(1, 16)), gap);
      end
      bursty = !tail && $urandom_range(0, 2) != 0;
      extra = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 15);
      for (int k = 0; k <= extra; k++) begin
        if (k != extra && $urandom_range(0, 19) == 0)
          set_node_count(CNT_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                          : $urandom_range(1, 16)), 0);
        n = live_nodes();
        r = $urandom_range(0, 9);
        if (r < 8) begin
          s = NODE_W'($urandom_range(0, n - 1));
          d = NODE_W'($urandom_range(0, n - 1));
          p = 1'b1;
        end else begin
          s = NODE_W'($urandom);
          d = NODE_W'($urandom);
          p = (r == 8);
        end
        gap = (bursty && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        send_item(s, d, p, k == extra, gap, 0, 0, 0);
        rand_items++;
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (node_verdicts.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("covered %0d graphs from %0d items, %0d with dropped edges, %0d count writes",
             graphs_done, items_sent, ovf_graphs, cfg_writes);
    $display("checked %0d node verdicts, %0d mismatches", results_checked, errors);
    if (errors == 0)
      $display("tb_eventual_safe_nodes OK");
    else
      $display("tb_eventual_safe_nodes NOT OK");
    $finish;
  end

endmodule
